/* hdl/sfb_pkg.sv */
package sfb_pkg;

	localparam int MAX_WIDTH = 4096;

	localparam int REG_W  = 13;
	localparam int KW     = 12;
	localparam int CH_W   = 8;
	localparam int NCH    = 3;
	localparam int EW     = $clog2(MAX_WIDTH + 1);
	localparam int CMPW   = (EW > KW) ? EW : KW;
	localparam int NUMW   = CH_W + EW;
	localparam int RW     = 32;
	localparam int PW     = NUMW + RW;
	localparam int CNT_W  = $clog2(RW);

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic REG_OVERLAP_WIDTH = 1'b0;

	localparam int S_TDATA_W = ((KW + 2 * NCH * CH_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((NCH * CH_W + 7) / 8) * 8;

	typedef logic [NCH-1:0][CH_W-1:0] pix3_t;

	typedef struct packed {
		logic                      pass;
		pix3_t                     base;
		logic [NCH-1:0][NUMW-1:0]  num;
	} mix_t;

endpackage

/* hdl/sfb_recip.sv */
module sfb_recip (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sfb_pkg::EW-1:0]      width,
	output logic [sfb_pkg::RW-1:0]      recip,
	output logic                        busy
);

	logic [sfb_pkg::RW-1:0]    recip_q;
	logic [sfb_pkg::EW-1:0]    rem_q;
	logic [sfb_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic [sfb_pkg::EW:0]      rem_sh;
	logic                      fits;

	// floor(2^RW / width), one quotient bit per cycle
	always_comb begin
		rem_sh = {rem_q, 1'b0};
		fits   = rem_sh >= {1'b0, width};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recip_q <= '1;
			rem_q   <= '0;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
		end else if (start) begin
			cnt_q <= '0;
			rem_q <= sfb_pkg::EW'(1);
			if (width == sfb_pkg::EW'(1)) begin
				recip_q <= '1;
				busy_q  <= 1'b0;
			end else begin
				busy_q <= 1'b1;
			end
		end else if (busy_q) begin
			rem_q   <= fits ? sfb_pkg::EW'(rem_sh - {1'b0, width}) : rem_sh[sfb_pkg::EW-1:0];
			recip_q <= {recip_q[sfb_pkg::RW-2:0], fits};
			cnt_q   <= cnt_q + 1'b1;
			if (cnt_q == sfb_pkg::CNT_W'(sfb_pkg::RW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign recip = recip_q;
	assign busy  = busy_q;

endmodule

/* hdl/sfb_mix.sv */
module sfb_mix (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sfb_pkg::KW-1:0]      column_offset,
	input  sfb_pkg::pix3_t              base,
	input  sfb_pkg::pix3_t              warp,
	input  logic [sfb_pkg::EW-1:0]      width,
	output logic                        out_valid,
	input  logic                        out_ready,
	output sfb_pkg::mix_t               out_data
);

	logic                         v_s1;
	logic [sfb_pkg::KW-1:0]       k_s1;
	logic [sfb_pkg::EW-1:0]       wk_s1;
	sfb_pkg::pix3_t               base_s1;
	sfb_pkg::pix3_t               warp_s1;
	logic                         pass_s1;

	logic                         v_s2;
	sfb_pkg::mix_t                mix_s2;

	logic                         en_s1;
	logic                         en_s2;
	logic [sfb_pkg::CMPW-1:0]     k_c;
	logic [sfb_pkg::CMPW-1:0]     w_c;
	logic [sfb_pkg::CMPW-1:0]     k_clip;
	logic [sfb_pkg::KW-1:0]       k_eff;
	sfb_pkg::mix_t                mix_d;
	logic [sfb_pkg::NUMW-1:0]     pb;
	logic [sfb_pkg::NUMW-1:0]     pw;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_comb begin
		k_c    = sfb_pkg::CMPW'(column_offset);
		w_c    = sfb_pkg::CMPW'(width);
		k_clip = (k_c >= w_c) ? w_c - 1'b1 : k_c;
		k_eff  = sfb_pkg::KW'(k_clip);
	end

	always_comb begin
		mix_d.pass = pass_s1;
		mix_d.base = base_s1;
		mix_d.num  = '0;
		pb         = '0;
		pw         = '0;
		for (int c = 0; c < sfb_pkg::NCH; c++) begin
			pb = sfb_pkg::NUMW'(base_s1[c]) * sfb_pkg::NUMW'(wk_s1);
			pw = sfb_pkg::NUMW'(warp_s1[c]) * sfb_pkg::NUMW'(k_s1);
			mix_d.num[c] = pb + pw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			k_s1    <= k_eff;
			wk_s1   <= width - sfb_pkg::EW'(k_eff);
			base_s1 <= base;
			warp_s1 <= warp;
			pass_s1 <= (warp == '0);
		end
		if (en_s2 && v_s1) begin
			mix_s2 <= mix_d;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = mix_s2;

endmodule

/* hdl/sfb_quot.sv */
module sfb_quot (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  sfb_pkg::mix_t               in_data,
	input  logic [sfb_pkg::EW-1:0]      width,
	input  logic [sfb_pkg::RW-1:0]      recip,
	output logic                        out_valid,
	input  logic                        out_ready,
	output sfb_pkg::pix3_t              out_pix
);

	logic                                      v_s3;
	logic                                      v_s4;
	logic                                      v_s5;
	sfb_pkg::mix_t                             mix_s3;
	sfb_pkg::mix_t                             mix_s4;
	logic [sfb_pkg::NCH-1:0][sfb_pkg::CH_W-1:0] qe_s3;
	logic [sfb_pkg::NCH-1:0][sfb_pkg::CH_W-1:0] qe_s4;
	logic [sfb_pkg::NCH-1:0][sfb_pkg::NUMW-1:0] qw_s4;
	sfb_pkg::pix3_t                            pix_s5;

	logic en_s3;
	logic en_s4;
	logic en_s5;

	logic [sfb_pkg::PW-1:0]                    prod;
	logic [sfb_pkg::NCH-1:0][sfb_pkg::CH_W-1:0] qe_d;
	logic [sfb_pkg::NCH-1:0][sfb_pkg::NUMW-1:0] qw_d;
	logic [sfb_pkg::NUMW-1:0]                  rem;
	sfb_pkg::pix3_t                            pix_d;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	// quotient estimate from the reciprocal: exact or one low
	always_comb begin
		qe_d = '0;
		prod = '0;
		for (int c = 0; c < sfb_pkg::NCH; c++) begin
			prod    = sfb_pkg::PW'(in_data.num[c]) * sfb_pkg::PW'(recip);
			qe_d[c] = prod[sfb_pkg::RW +: sfb_pkg::CH_W];
		end
	end

	always_comb begin
		qw_d = '0;
		for (int c = 0; c < sfb_pkg::NCH; c++) begin
			qw_d[c] = sfb_pkg::NUMW'(qe_s3[c]) * sfb_pkg::NUMW'(width);
		end
	end

	always_comb begin
		pix_d = '0;
		rem   = '0;
		for (int c = 0; c < sfb_pkg::NCH; c++) begin
			rem = mix_s4.num[c] - qw_s4[c];
			if (mix_s4.pass) begin
				pix_d[c] = mix_s4.base[c];
			end else if (rem >= sfb_pkg::NUMW'(width)) begin
				pix_d[c] = qe_s4[c] + 1'b1;
			end else begin
				pix_d[c] = qe_s4[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			mix_s3 <= in_data;
			qe_s3  <= qe_d;
		end
		if (en_s4 && v_s3) begin
			mix_s4 <= mix_s3;
			qe_s4  <= qe_s3;
			qw_s4  <= qw_d;
		end
		if (en_s5 && v_s4) begin
			pix_s5 <= pix_d;
		end
	end

	assign out_valid = v_s5;
	assign out_pix   = pix_s5;

endmodule

/* hdl/seam_linear_feather_blend.sv */
// Each accepted input beat passes through registered stages s1 to s5 before its output beat.
// Throughput: one beat per cycle while m_axis_tready is high and no reciprocal update is
// pending, set by the five-stage multiply pipeline. After an overlap_width write,
// s_axis_tready is low while start_q is set and the reciprocal unit computes floor(2^32 / width).
// Reset: overlap_width returns to 1, the pipeline empties, reciprocal is preset.
module seam_linear_feather_blend (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// column_offset[11:0], base_ch0, base_ch1, base_ch2, warp_ch0, warp_ch1, warp_ch2, pad
	input  logic [sfb_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// out_ch0[7:0], out_ch1[15:8], out_ch2[23:16]
	output logic [sfb_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sfb_pkg::APB_AW-1:0]        paddr,
	input  logic [sfb_pkg::APB_DW-1:0]        pwdata,
	output logic [sfb_pkg::APB_DW-1:0]        prdata,
	output logic                              pready
);

	logic [sfb_pkg::REG_W-1:0]  width_q;
	logic [sfb_pkg::EW-1:0]     w_eff;
	logic                       cfg_wr;
	logic                       sel_width;
	logic [sfb_pkg::RW-1:0]     recip;
	logic                       busy;

	logic [sfb_pkg::KW-1:0]     column_offset;
	sfb_pkg::pix3_t             base;
	sfb_pkg::pix3_t             warp;
	sfb_pkg::pix3_t             out_pix;

	logic                       mix_in_ready;
	logic                       mix_valid;
	logic                       quot_ready;
	sfb_pkg::mix_t              mix_data;

	assign pready    = 1'b1;
	assign sel_width = (paddr[2] == sfb_pkg::REG_OVERLAP_WIDTH);
	assign cfg_wr    = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (sel_width) prdata = sfb_pkg::APB_DW'(width_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= sfb_pkg::REG_W'(1);
		end else if (cfg_wr && sel_width) begin
			width_q <= pwdata[sfb_pkg::REG_W-1:0];
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_eff = sfb_pkg::EW'(1);
		end else if (sfb_pkg::CMPW'(width_q) > sfb_pkg::CMPW'(sfb_pkg::MAX_WIDTH)) begin
			w_eff = sfb_pkg::EW'(sfb_pkg::MAX_WIDTH);
		end else begin
			w_eff = sfb_pkg::EW'(width_q);
		end
	end

	// start_q registers the write, so the reciprocal unit starts once the register holds the new width
	logic start_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
		end else begin
			start_q <= cfg_wr && sel_width;
		end
	end

	sfb_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.width  (w_eff),
		.recip  (recip),
		.busy   (busy)
	);

	always_comb begin
		column_offset = s_axis_tdata[sfb_pkg::KW-1:0];
		for (int c = 0; c < sfb_pkg::NCH; c++) begin
			base[c] = s_axis_tdata[sfb_pkg::KW + c * sfb_pkg::CH_W +: sfb_pkg::CH_W];
			warp[c] = s_axis_tdata[sfb_pkg::KW + (sfb_pkg::NCH + c) * sfb_pkg::CH_W +:
				sfb_pkg::CH_W];
		end
	end

	assign s_axis_tready = mix_in_ready && !busy && !start_q;

	sfb_mix u_mix (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid && !busy && !start_q),
		.in_ready      (mix_in_ready),
		.column_offset (column_offset),
		.base          (base),
		.warp          (warp),
		.width         (w_eff),
		.out_valid     (mix_valid),
		.out_ready     (quot_ready),
		.out_data      (mix_data)
	);

	sfb_quot u_quot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mix_valid),
		.in_ready  (quot_ready),
		.in_data   (mix_data),
		.width     (w_eff),
		.recip     (recip),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pix   (out_pix)
	);

	assign m_axis_tdata = sfb_pkg::M_TDATA_W'(out_pix);

endmodule
